// ----- sv/pulse_width_frame_receiver_core_macros.svh -----
// ----------------------------------------------------------------------------
// Pulse-width frame receiver assertion macros
// Shared helpers for the concurrent checks of the receiver core.
// ----------------------------------------------------------------------------
`ifndef PULSE_WIDTH_FRAME_RECEIVER_CORE_MACROS_SVH
`define PULSE_WIDTH_FRAME_RECEIVER_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define PWFR_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define PWFR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/pwfr_pkg.sv -----
// ----------------------------------------------------------------------------
// Pulse-width frame receiver package
// Sizes, register indexes, event and mode codes shared by the receiver.
// ----------------------------------------------------------------------------
package pwfr_pkg;

    // Frame store capacity in bytes (1 to 64).
    localparam int MAX_BYTES   = 16;
    localparam int BIT_CAP_INT = MAX_BYTES * 8;
    localparam int BIT_W       = $clog2(BIT_CAP_INT + 1);
    localparam int IDX_W       = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;
    localparam int BYTE_CNT_W  = BIT_W - 2;
    localparam logic [BIT_W-1:0] BIT_CAP = BIT_W'(BIT_CAP_INT);

    // Port widths fixed by the interface.
    localparam int WIDTH_W     = 16;
    localparam int KIND_W      = 3;
    localparam int HELD_W      = 10;
    localparam int INDEX_W     = 6;
    localparam int MODE_W      = 2;
    localparam int TALLY_W     = 32;

    // Configuration registers.
    localparam int NUM_REGS    = 7;
    localparam int REG_IDX_W   = 3;
    localparam logic [REG_IDX_W-1:0] REG_SYNC_MIN  = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_SYNC_MAX  = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_ZERO_MIN  = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_ZERO_MAX  = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_ONE_MIN   = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_ONE_LIMIT = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_STOP_MIN  = 3'd6;

    localparam logic [WIDTH_W-1:0] CFG_RESET [NUM_REGS] = '{
        16'd800, 16'd1200, 16'd40, 16'd80, 16'd100, 16'd160, 16'd300
    };

    // Event codes.
    localparam logic [KIND_W-1:0] EV_IGNORED = 3'd0;
    localparam logic [KIND_W-1:0] EV_SYNC    = 3'd1;
    localparam logic [KIND_W-1:0] EV_BIT     = 3'd2;
    localparam logic [KIND_W-1:0] EV_BYTE    = 3'd3;
    localparam logic [KIND_W-1:0] EV_ERROR   = 3'd4;
    localparam logic [KIND_W-1:0] EV_RESET   = 3'd5;

    // Receiver modes.
    localparam logic [MODE_W-1:0] MODE_IDLE      = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SYNCED    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_RECEIVING = 2'd2;

    // Flags of the shared comparator.
    typedef struct packed {
        logic lt;
        logic eq;
    } cmp_res_t;

endpackage

// ----- sv/pwfr_cmp.sv -----
// ----------------------------------------------------------------------------
// Pulse-width frame receiver comparator
// Shared magnitude comparator: one subtraction yields less-than and equal.
// ----------------------------------------------------------------------------
module pwfr_cmp
    import pwfr_pkg::*;
(
    input  logic [WIDTH_W-1:0] lhs,
    input  logic [WIDTH_W-1:0] rhs,
    output cmp_res_t           res
);

    logic [WIDTH_W:0] diff;

    // The borrow out of the subtraction marks lhs below rhs.
    assign diff   = {1'b0, lhs} - {1'b0, rhs};
    assign res.lt = diff[WIDTH_W];
    assign res.eq = (diff[WIDTH_W-1:0] == '0);

endmodule

// ----- sv/pulse_width_frame_receiver_core.sv -----
// A pulse passes through the seven threshold compares, done one per cycle on one shared
// comparator, then the decide state and the report or emit state; a reset command skips
// the compares. A new request is accepted only in idle; a stop pulse with stored bytes emits
// one byte per cycle while the result channel does not stall, in place of its single report.
// Reset (rst_n, asynchronous, active low) clears the frame, counters and mode at once,
// and loads the registers with their default windows; no clearing pass is needed.
// ----------------------------------------------------------------------------
// Pulse-width frame receiver core
// Classifies low-pulse widths against configured windows, collects frame
// bits LSB first and emits the stored bytes when a stop pulse arrives.
// ----------------------------------------------------------------------------
module pulse_width_frame_receiver_core
    import pwfr_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    // Configuration write port
    input  logic                 cfg_wr_en,
    input  logic [REG_IDX_W-1:0] cfg_index,
    input  logic [WIDTH_W-1:0]   cfg_data,
    // Request channel
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic                 func,
    input  logic [WIDTH_W-1:0]   pulse_width_us,
    // Result channel
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [KIND_W-1:0]    event_kind,
    output logic [7:0]           data_byte,
    output logic [INDEX_W-1:0]   byte_index,
    output logic                 last,
    output logic [HELD_W-1:0]    bits_held,
    output logic [MODE_W-1:0]    receiver_state,
    output logic [TALLY_W-1:0]   frames_done,
    output logic [TALLY_W-1:0]   errors_seen
);

`include "pulse_width_frame_receiver_core_macros.svh"

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_CMP    = 5'b00010,
        S_DECIDE = 5'b00100,
        S_REPORT = 5'b01000,
        S_EMIT   = 5'b10000
    } state_t;

    state_t                 state_reg, state_next;
    logic [WIDTH_W-1:0]     cfg_reg [NUM_REGS];
    logic [MODE_W-1:0]      mode_reg;
    logic [7:0]             frame_store_reg [MAX_BYTES];
    logic [BIT_W-1:0]       bit_total_reg;
    logic [TALLY_W-1:0]     frame_tally_reg;
    logic [TALLY_W-1:0]     error_tally_reg;
    logic                   func_reg;
    logic [WIDTH_W-1:0]     width_reg;
    logic [REG_IDX_W-1:0]   step_reg;
    logic [NUM_REGS-1:0]    hit_reg;
    logic [KIND_W-1:0]      kind_reg;
    logic [IDX_W-1:0]       idx_reg;
    logic [IDX_W-1:0]       last_idx_reg;
    logic                   out_valid_reg;
    logic [KIND_W-1:0]      out_kind_reg;
    logic [7:0]             out_data_reg;
    logic [INDEX_W-1:0]     out_index_reg;
    logic                   out_last_reg;
    logic [HELD_W-1:0]      out_held_reg;
    logic [MODE_W-1:0]      out_mode_reg;
    logic [TALLY_W-1:0]     out_frames_reg;
    logic [TALLY_W-1:0]     out_errors_reg;

    cmp_res_t               cmp_res;
    logic                   hit_now;
    logic                   in_accept;
    logic                   out_free;
    logic                   out_load;
    logic                   is_sync;
    logic                   is_zero;
    logic                   is_one;
    logic                   is_stop;
    logic                   store_full;
    logic                   dec_emit;
    logic [BYTE_CNT_W-1:0]  bytes_used;

    // Handshake terms.
    assign in_stall  = (state_reg != S_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign out_load  = out_free && ((state_reg == S_REPORT) || (state_reg == S_EMIT));

    // Shared comparator: the held width against the threshold of this step.
    pwfr_cmp u_cmp (
        .lhs (width_reg),
        .rhs (cfg_reg[step_reg]),
        .res (cmp_res)
    );

    // Each step tests the width against one bound of its window.
    always_comb
    begin
        case (step_reg)
            REG_SYNC_MIN, REG_ZERO_MIN, REG_ONE_MIN, REG_STOP_MIN:
                hit_now = !cmp_res.lt;
            REG_SYNC_MAX, REG_ZERO_MAX:
                hit_now = cmp_res.lt || cmp_res.eq;
            REG_ONE_LIMIT:
                hit_now = cmp_res.lt;
            default:
                hit_now = 1'b0;
        endcase
    end

    // Window classification from the collected compare flags.
    assign is_sync    = hit_reg[REG_SYNC_MIN] && hit_reg[REG_SYNC_MAX];
    assign is_zero    = hit_reg[REG_ZERO_MIN] && hit_reg[REG_ZERO_MAX];
    assign is_one     = hit_reg[REG_ONE_MIN] && hit_reg[REG_ONE_LIMIT];
    assign is_stop    = hit_reg[REG_STOP_MIN];
    assign store_full = (bit_total_reg == BIT_CAP);
    assign bytes_used = BYTE_CNT_W'(bit_total_reg[BIT_W-1:3])
                      + BYTE_CNT_W'(|bit_total_reg[2:0]);
    assign dec_emit   = !func_reg && !is_sync && (mode_reg != MODE_IDLE)
                      && !(is_zero || is_one) && is_stop && (bytes_used != '0);

    // Sequencer.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = func ? S_DECIDE : S_CMP;
                end
            end
            S_CMP:
            begin
                if (step_reg == REG_STOP_MIN)
                begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                state_next = dec_emit ? S_EMIT : S_REPORT;
            end
            S_REPORT:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            S_EMIT:
            begin
                if (out_free && (idx_reg == last_idx_reg))
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_REGS; i++)
            begin
                cfg_reg[i] <= CFG_RESET[i];
            end
        end
        else if (cfg_wr_en && (cfg_index < REG_IDX_W'(NUM_REGS)))
        begin
            cfg_reg[cfg_index] <= cfg_data;
        end
    end

    // Control state, frame store and counters.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            mode_reg        <= MODE_IDLE;
            bit_total_reg   <= '0;
            frame_tally_reg <= '0;
            error_tally_reg <= '0;
            step_reg        <= '0;
            hit_reg         <= '0;
            idx_reg         <= '0;
            out_valid_reg   <= 1'b0;
            for (int i = 0; i < MAX_BYTES; i++)
            begin
                frame_store_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;

            // The result register fills when free and empties once taken.
            out_valid_reg <= out_load || (out_valid_reg && out_stall);

            case (state_reg)
                S_IDLE:
                begin
                    step_reg <= '0;
                    hit_reg  <= '0;
                end
                S_CMP:
                begin
                    hit_reg[step_reg] <= hit_now;
                    step_reg          <= step_reg + 1'b1;
                end
                S_DECIDE:
                begin
                    idx_reg <= '0;
                    if (func_reg || is_sync)
                    begin
                        bit_total_reg <= '0;
                        mode_reg      <= func_reg ? MODE_IDLE : MODE_SYNCED;
                        for (int i = 0; i < MAX_BYTES; i++)
                        begin
                            frame_store_reg[i] <= '0;
                        end
                    end
                    else if (mode_reg == MODE_IDLE)
                    begin
                        mode_reg <= MODE_IDLE;
                    end
                    else if (is_zero || is_one)
                    begin
                        mode_reg <= MODE_RECEIVING;
                        if (!store_full)
                        begin
                            frame_store_reg[bit_total_reg[IDX_W+2:3]][bit_total_reg[2:0]]
                                <= !is_zero;
                            bit_total_reg <= bit_total_reg + 1'b1;
                        end
                    end
                    else if (is_stop)
                    begin
                        frame_tally_reg <= frame_tally_reg + 1'b1;
                        mode_reg        <= MODE_IDLE;
                    end
                    else
                    begin
                        error_tally_reg <= error_tally_reg + 1'b1;
                        bit_total_reg   <= '0;
                        mode_reg        <= MODE_IDLE;
                        for (int i = 0; i < MAX_BYTES; i++)
                        begin
                            frame_store_reg[i] <= '0;
                        end
                    end
                end
                S_EMIT:
                begin
                    if (out_free)
                    begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // Request capture and decision payload.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            func_reg  <= func;
            width_reg <= pulse_width_us;
        end
        if (state_reg == S_DECIDE)
        begin
            last_idx_reg <= IDX_W'(bytes_used - 1'b1);
            if (func_reg)
            begin
                kind_reg <= EV_RESET;
            end
            else if (is_sync)
            begin
                kind_reg <= EV_SYNC;
            end
            else if (mode_reg == MODE_IDLE)
            begin
                kind_reg <= EV_IGNORED;
            end
            else if (is_zero || is_one)
            begin
                kind_reg <= store_full ? EV_IGNORED : EV_BIT;
            end
            else if (is_stop)
            begin
                kind_reg <= EV_BYTE;
            end
            else
            begin
                kind_reg <= EV_ERROR;
            end
        end
    end

    // Result register: single reports, or one stored byte per cycle while the channel does not stall.
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_held_reg   <= HELD_W'(bit_total_reg);
            out_mode_reg   <= mode_reg;
            out_frames_reg <= frame_tally_reg;
            out_errors_reg <= error_tally_reg;
            if (state_reg == S_EMIT)
            begin
                out_kind_reg  <= EV_BYTE;
                out_data_reg  <= frame_store_reg[idx_reg];
                out_index_reg <= INDEX_W'(idx_reg);
                out_last_reg  <= (idx_reg == last_idx_reg);
            end
            else
            begin
                out_kind_reg  <= kind_reg;
                out_data_reg  <= '0;
                out_index_reg <= '0;
                out_last_reg  <= 1'b1;
            end
        end
    end

    assign out_valid      = out_valid_reg;
    assign event_kind     = out_kind_reg;
    assign data_byte      = out_data_reg;
    assign byte_index     = out_index_reg;
    assign last           = out_last_reg;
    assign bits_held      = out_held_reg;
    assign receiver_state = out_mode_reg;
    assign frames_done    = out_frames_reg;
    assign errors_seen    = out_errors_reg;

    // Checks on the sequencer and frame store.
    `PWFR_ASSERT_NEXT(a_accept_busy, in_accept,
        (state_reg == S_CMP) || (state_reg == S_DECIDE),
        "accepted request did not start the sequencer")
    `PWFR_ASSERT_NOW(a_bits_cap, 1'b1, bit_total_reg <= BIT_CAP,
        "frame bit count beyond store capacity")
    `PWFR_ASSERT_NOW(a_emit_range, state_reg == S_EMIT, idx_reg <= last_idx_reg,
        "byte emission ran past the last stored byte")
    `PWFR_ASSERT_NEXT(a_emit_end,
        (state_reg == S_EMIT) && out_free && (idx_reg == last_idx_reg),
        (state_reg == S_IDLE) && out_valid_reg && out_last_reg,
        "final frame byte not marked last")

endmodule

// ----- bench/pulse_width_frame_receiver_core_tb.sv -----
// ----------------------------------------------------------------------------
// Pulse-width frame receiver core testbench
// Drives pulse widths and reset commands through the request channel, predicts
// every report with a behavioural copy of the receiver and compares the
// reports field by field. Runs a directed set, then random frame traffic under
// several window settings and idling patterns.
// ----------------------------------------------------------------------------
module pulse_width_frame_receiver_core_tb
    import pwfr_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    // One request as presented on the request channel.
    typedef struct packed {
        logic               func;
        logic [WIDTH_W-1:0] width;
    } pulse_req_t;

    // One report as produced on the result channel.
    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [7:0]         data;
        logic [INDEX_W-1:0] idx;
        logic               last;
        logic [HELD_W-1:0]  held;
        logic [MODE_W-1:0]  mode;
        logic [TALLY_W-1:0] frames;
        logic [TALLY_W-1:0] errors;
    } rx_report_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_wr_en = 1'b0;
    logic [REG_IDX_W-1:0] cfg_index = REG_SYNC_MIN;
    logic [WIDTH_W-1:0]   cfg_data = '0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    logic                 func = 1'b0;
    logic [WIDTH_W-1:0]   pulse_width_us = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic [KIND_W-1:0]    event_kind;
    logic [7:0]           data_byte;
    logic [INDEX_W-1:0]   byte_index;
    logic                 last;
    logic [HELD_W-1:0]    bits_held;
    logic [MODE_W-1:0]    receiver_state;
    logic [TALLY_W-1:0]   frames_done;
    logic [TALLY_W-1:0]   errors_seen;

    // Pending requests, awaited reports and run bookkeeping.
    pulse_req_t pulse_q[$];
    rx_report_t report_q[$];
    pulse_req_t next_req;
    rx_report_t mon_seen;
    rx_report_t mon_want;
    int         send_idle_pct = 0;
    int         recv_stall_pct = 0;
    int         fail_count = 0;

    // Behavioural copy of the receiver: windows, mode, frame store and tallies.
    logic [WIDTH_W-1:0] win [NUM_REGS];
    logic [MODE_W-1:0]  rx_mode_m;
    logic [7:0]         frame_bytes [MAX_BYTES];
    int                 held_bits_m;
    logic [TALLY_W-1:0] frames_m;
    logic [TALLY_W-1:0] errors_m;

    pulse_width_frame_receiver_core u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .func           (func),
        .pulse_width_us (pulse_width_us),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .event_kind     (event_kind),
        .data_byte      (data_byte),
        .byte_index     (byte_index),
        .last           (last),
        .bits_held      (bits_held),
        .receiver_state (receiver_state),
        .frames_done    (frames_done),
        .errors_seen    (errors_seen)
    );

    // Clock generation.
    initial
    begin
        forever #10 clk = ~clk;
    end

    // Records a failure; only the first ten are described in full.
    function automatic void note_failure(input string msg);
        fail_count++;
        if (fail_count <= 10)
            $display("%s", msg);
    endfunction

    // Queues the report that the receiver should give in its present state.
    function automatic void post_report(input logic [KIND_W-1:0] kind, input logic [7:0] data,
                                        input int idx, input logic lst);
        report_q.push_back('{kind, data, INDEX_W'(idx), lst, HELD_W'(held_bits_m),
                             rx_mode_m, frames_m, errors_m});
    endfunction

    function automatic void clear_frame_copy();
        foreach (frame_bytes[i])
            frame_bytes[i] = '0;
        held_bits_m = 0;
    endfunction

    // Classifies one accepted request and queues the reports it causes.
    function automatic void classify_pulse(input logic f, input logic [WIDTH_W-1:0] w);
        logic in_sync;
        logic in_zero;
        logic in_one;
        int   nbytes;
        in_sync = (w >= win[REG_SYNC_MIN]) && (w <= win[REG_SYNC_MAX]);
        in_zero = (w >= win[REG_ZERO_MIN]) && (w <= win[REG_ZERO_MAX]);
        in_one  = (w >= win[REG_ONE_MIN]) && (w < win[REG_ONE_LIMIT]);
        if (f)
        begin
            clear_frame_copy();
            rx_mode_m = MODE_IDLE;
            post_report(EV_RESET, 8'h00, 0, 1'b1);
        end
        else if (in_sync)
        begin
            clear_frame_copy();
            rx_mode_m = MODE_SYNCED;
            post_report(EV_SYNC, 8'h00, 0, 1'b1);
        end
        else if (rx_mode_m == MODE_IDLE)
        begin
            post_report(EV_IGNORED, 8'h00, 0, 1'b1);
        end
        else if (in_zero || in_one)
        begin
            // Bits go in LSB first; once the store is full they are dropped.
            rx_mode_m = MODE_RECEIVING;
            if (held_bits_m < MAX_BYTES * 8)
            begin
                frame_bytes[held_bits_m / 8][held_bits_m % 8] = !in_zero;
                held_bits_m++;
                post_report(EV_BIT, 8'h00, 0, 1'b1);
            end
            else
                post_report(EV_IGNORED, 8'h00, 0, 1'b1);
        end
        else if (w >= win[REG_STOP_MIN])
        begin
            // A stop emits every stored byte; an empty frame gives one zero byte.
            frames_m++;
            rx_mode_m = MODE_IDLE;
            nbytes = (held_bits_m + 7) / 8;
            if (nbytes == 0)
                post_report(EV_BYTE, 8'h00, 0, 1'b1);
            else
                for (int i = 0; i < nbytes; i++)
                    post_report(EV_BYTE, frame_bytes[i], i, i == nbytes - 1);
        end
        else
        begin
            errors_m++;
            clear_frame_copy();
            rx_mode_m = MODE_IDLE;
            post_report(EV_ERROR, 8'h00, 0, 1'b1);
        end
    endfunction

    // Request driver: presents queued requests, holding each while stalled.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                classify_pulse(func, pulse_width_us);
            if (!in_valid || !in_stall)
            begin
                if (pulse_q.size() != 0 && $urandom_range(99, 0) >= send_idle_pct)
                begin
                    next_req = pulse_q.pop_front();
                    in_valid <= 1'b1;
                    func <= next_req.func;
                    pulse_width_us <= next_req.width;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Report monitor: checks each accepted report and drives the stall.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                mon_seen = '{event_kind, data_byte, byte_index, last, bits_held,
                             receiver_state, frames_done, errors_seen};
                if (report_q.size() == 0)
                    note_failure($sformatf("unexpected report: kind %0d data %h index %0d",
                                           event_kind, data_byte, byte_index));
                else
                begin
                    mon_want = report_q.pop_front();
                    if (mon_seen !== mon_want)
                        note_failure($sformatf({"report mismatch: expected kind %0d data %h ",
                            "idx %0d last %0d held %0d state %0d frames %0d errors %0d; got ",
                            "kind %0d data %h idx %0d last %0d held %0d state %0d frames %0d ",
                            "errors %0d"},
                            mon_want.kind, mon_want.data, mon_want.idx, mon_want.last,
                            mon_want.held, mon_want.mode, mon_want.frames, mon_want.errors,
                            mon_seen.kind, mon_seen.data, mon_seen.idx, mon_seen.last,
                            mon_seen.held, mon_seen.mode, mon_seen.frames, mon_seen.errors));
                end
            end
            out_stall <= ($urandom_range(99, 0) < recv_stall_pct);
        end
    end

    function automatic void queue_pulse(input logic f, input int w);
        pulse_q.push_back('{f, WIDTH_W'(w)});
    endfunction

    // Random width within [lo, hi]; an empty window gives any width at all.
    function automatic int pick_in(input int lo, input int hi);
        if (lo <= hi)
            return $urandom_range(hi, lo);
        return $urandom_range(65535, 0);
    endfunction

    function automatic int sync_width();
        return pick_in(int'(win[REG_SYNC_MIN]), int'(win[REG_SYNC_MAX]));
    endfunction

    function automatic int bit_width();
        if ($urandom_range(1, 0))
            return pick_in(int'(win[REG_ZERO_MIN]), int'(win[REG_ZERO_MAX]));
        return pick_in(int'(win[REG_ONE_MIN]), int'(win[REG_ONE_LIMIT]) - 1);
    endfunction

    // Stop widths are kept clear of the sync window where the windows allow it.
    function automatic int stop_width();
        if (win[REG_STOP_MIN] < win[REG_SYNC_MIN])
            return pick_in(int'(win[REG_STOP_MIN]), int'(win[REG_SYNC_MIN]) - 1);
        return pick_in(int'(win[REG_STOP_MIN]), 65535);
    endfunction

    // Random traffic: mostly whole frames, the rest noise and broken frames.
    task automatic gen_traffic(input int budget, input bit with_full_frame);
        int target;
        int nbits;
        int r;
        target = pulse_q.size() + budget;
        if (with_full_frame)
        begin
            // Overfills the store so that the surplus bits are dropped.
            queue_pulse(1'b0, sync_width());
            nbits = $urandom_range(140, 130);
            repeat (nbits) queue_pulse(1'b0, bit_width());
            queue_pulse(1'b0, stop_width());
        end
        while (pulse_q.size() < target)
        begin
            r = $urandom_range(99, 0);
            if (r < 70)
            begin
                queue_pulse(1'b0, sync_width());
                nbits = ($urandom_range(9, 0) == 0) ? $urandom_range(40, 17)
                                                     : $urandom_range(16, 0);
                repeat (nbits) queue_pulse(1'b0, bit_width());
                queue_pulse(1'b0, stop_width());
            end
            else if (r < 85)
            begin
                queue_pulse($urandom_range(3, 0) == 0, $urandom_range(65535, 0));
            end
            else
            begin
                queue_pulse(1'b0, sync_width());
                repeat ($urandom_range(5, 0)) queue_pulse(1'b0, bit_width());
                case ($urandom_range(2, 0))
                    0: queue_pulse(1'b0, $urandom_range(65535, 0));
                    1: queue_pulse(1'b1, $urandom_range(65535, 0));
                    default: queue_pulse(1'b0, sync_width());
                endcase
            end
        end
    endtask

    // Waits until every request has gone and every report has come back.
    task automatic drain();
        do
            @(negedge clk);
        while (pulse_q.size() != 0 || in_valid || report_q.size() != 0);
    endtask

    task automatic set_window(input logic [REG_IDX_W-1:0] idx, input logic [WIDTH_W-1:0] v);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v;
        win[idx] = v;
    endtask

    task automatic set_all_windows(input int s_lo, input int s_hi, input int z_lo,
                                   input int z_hi, input int o_lo, input int o_lim,
                                   input int stop);
        set_window(REG_SYNC_MIN, WIDTH_W'(s_lo));
        set_window(REG_SYNC_MAX, WIDTH_W'(s_hi));
        set_window(REG_ZERO_MIN, WIDTH_W'(z_lo));
        set_window(REG_ZERO_MAX, WIDTH_W'(z_hi));
        set_window(REG_ONE_MIN, WIDTH_W'(o_lo));
        set_window(REG_ONE_LIMIT, WIDTH_W'(o_lim));
        set_window(REG_STOP_MIN, WIDTH_W'(stop));
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    // Run ceiling, far beyond the slowest correct run.
    initial
    begin
        #20ms;
        $display("tb: failure");
        $finish;
    end

    // Main sequence: reset, directed requests, then random phases.
    initial
    begin
        win[REG_SYNC_MIN]  = 16'd800;
        win[REG_SYNC_MAX]  = 16'd1200;
        win[REG_ZERO_MIN]  = 16'd40;
        win[REG_ZERO_MAX]  = 16'd80;
        win[REG_ONE_MIN]   = 16'd100;
        win[REG_ONE_LIMIT] = 16'd160;
        win[REG_STOP_MIN]  = 16'd300;
        rx_mode_m = MODE_IDLE;
        clear_frame_copy();
        frames_m = '0;
        errors_m = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Directed requests under the default windows.
        queue_pulse(1'b1, 65535);  // reset command while idle
        queue_pulse(1'b0, 0);      // idle pulses are ignored
        queue_pulse(1'b0, 65535);
        queue_pulse(1'b0, 799);
        queue_pulse(1'b0, 800);    // sync at the lower edge
        queue_pulse(1'b0, 300);    // stop with nothing stored
        queue_pulse(1'b0, 1200);   // sync at the upper edge
        queue_pulse(1'b0, 40);
        queue_pulse(1'b0, 80);
        queue_pulse(1'b0, 100);
        queue_pulse(1'b0, 159);
        queue_pulse(1'b0, 1201);   // stop emits one byte
        queue_pulse(1'b0, 50);     // ignored; the stored bits still show
        queue_pulse(1'b0, 1000);
        queue_pulse(1'b0, 39);     // just below the bit-zero window
        queue_pulse(1'b0, 1000);
        queue_pulse(1'b0, 81);     // gap between the bit windows
        queue_pulse(1'b0, 1000);
        queue_pulse(1'b0, 160);    // bit-one limit is exclusive
        queue_pulse(1'b0, 900);
        queue_pulse(1'b0, 299);    // just below the stop threshold
        queue_pulse(1'b0, 900);
        queue_pulse(1'b0, 120);
        queue_pulse(1'b1, 0);      // reset command mid-frame
        drain();

        // Default windows, no idling, with a full pause half way.
        gen_traffic(40, 1'b0);
        drain();
        gen_traffic(40, 1'b0);
        drain();

        // Narrow windows at the range extremes; sender mostly idle.
        set_all_windows(2000, 2000, 0, 10, 11, 12, 65535);
        send_idle_pct = 70;
        recv_stall_pct = 0;
        gen_traffic(80, 1'b0);
        drain();

        // Overlapping bit windows and a zero stop threshold; receiver stalling.
        set_all_windows(500, 600, 10, 200, 150, 401, 0);
        send_idle_pct = 0;
        recv_stall_pct = 70;
        gen_traffic(80, 1'b0);
        drain();

        // Sync window up to the top of the range; both sides idling.
        set_all_windows(40000, 65535, 1, 20, 21, 31, 31);
        send_idle_pct = 25;
        recv_stall_pct = 25;
        gen_traffic(30, 1'b1);
        drain();

        repeat (12) @(posedge clk);
        if (fail_count == 0 && report_q.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
